// ----- rtl/sha256_pkg.sv -----
// SHA-256 constants, round constant table and round functions.
`timescale 1ns / 1ps
package sha256_pkg;

	typedef logic [31:0] word_t;
	typedef logic [5:0]  round_t;

	localparam word_t PAD_BYTE = 32'h0000_0080;

	localparam word_t H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_s0(input word_t x);
		big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_s1(input word_t x);
		big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_s0(input word_t x);
		small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_s1(input word_t x);
		small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

// ----- rtl/sha256_message_digest_top.sv -----
// SHA-256 digest engine: byte intake, block memory, round loop and digest output.
//
// Input channel: message_byte, byte_valid, end_of_message with in_valid/in_stall.
// A request is taken while the engine is idle. Each 64th byte starts a
// compression (a read-ahead state of the block memory, 64 rounds at one per
// cycle, a hash update state), during which in_stall is high. End of message
// adds a setup state and one or two compressions (two when more than 55 bytes
// sit in the last block).
// Output channel: digest_word, word_index, last_word with out_valid/out_stall;
// eight requests, word 0 first, one per cycle while out_stall is low.
// A stalled output word holds, and no input is taken until word 7 leaves;
// then the initial hash reloads and a new message may start.
// Reset clears the byte count, the fill level and the control state and loads
// the initial hash. Block memory contents need no reset.
`timescale 1ns / 1ps
module sha256_message_digest_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  message_byte,
	input  logic        byte_valid,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PAD   = 3'd1;
	localparam logic [2:0] ST_PRE   = 3'd2;
	localparam logic [2:0] ST_ROUND = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]              state_q;
	sha256_pkg::word_t       hash_q [8];
	sha256_pkg::word_t       v_q [8];
	sha256_pkg::word_t       win_q [16];
	sha256_pkg::word_t       mem [16];
	sha256_pkg::word_t       rdata_q;
	sha256_pkg::word_t       acc_q;
	logic [60:0]             count_q;
	logic [5:0]              fill_q;
	sha256_pkg::round_t      rnd_q;
	logic                    eom_q, pad_q, len_q, zero_q;
	logic [2:0]              oidx_q;

	logic                    in_acc, out_acc, mem_we;
	logic [3:0]              mem_waddr, mem_raddr;
	sha256_pkg::word_t       acc_next, pad_word, w_src, w_new, t1, t2;
	logic [4:0]              sh;
	logic [63:0]             bits;
	logic [3:0]              ridx;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = (state_q == ST_OUT);
	assign out_acc   = out_valid && !out_stall;
	assign digest_word = hash_q[oidx_q];
	assign word_index  = oidx_q;
	assign last_word   = (oidx_q == 3'd7);

	assign sh       = 5'd24 - {fill_q[1:0], 3'b000};
	assign acc_next = (fill_q[1:0] == 2'd0) ? {message_byte, 24'd0}
		: (acc_q | ({24'd0, message_byte} << sh));
	assign pad_word = ((fill_q[1:0] == 2'd0) ? 32'd0 : acc_q) | (sha256_pkg::PAD_BYTE << sh);
	assign bits     = {count_q, 3'b000};
	assign ridx     = rnd_q[3:0];

	assign mem_we    = in_acc && byte_valid && (fill_q[1:0] == 2'd3);
	assign mem_waddr = fill_q[5:2];
	assign mem_raddr = (state_q == ST_ROUND) ? (ridx + 4'd1) : 4'd0;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= acc_next;
		end
		rdata_q <= mem[mem_raddr];
	end

	always_comb begin
		w_src = rdata_q;
		if (len_q && ridx == 4'd14) begin
			w_src = bits[63:32];
		end else if (len_q && ridx == 4'd15) begin
			w_src = bits[31:0];
		end else if (zero_q) begin
			w_src = '0;
		end else if (pad_q) begin
			if (ridx == fill_q[5:2]) begin
				w_src = pad_word;
			end else if (ridx > fill_q[5:2]) begin
				w_src = '0;
			end
		end
		if (rnd_q[5:4] != 2'd0) begin
			w_new = win_q[0] + sha256_pkg::small_s0(win_q[1]) + win_q[9]
				+ sha256_pkg::small_s1(win_q[14]);
		end else begin
			w_new = w_src;
		end
		t1 = v_q[7] + sha256_pkg::big_s1(v_q[4])
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ sha256_pkg::ROUND_K[rnd_q] + w_new;
		t2 = sha256_pkg::big_s0(v_q[0])
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk) begin
		if (in_acc && byte_valid) begin
			acc_q <= acc_next;
		end
		if (state_q == ST_PRE) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= hash_q[i];
			end
		end else if (state_q == ST_ROUND) begin
			for (int i = 1; i < 8; i++) begin
				v_q[i] <= v_q[i-1];
			end
			v_q[4] <= v_q[3] + t1;
			v_q[0] <= t1 + t2;
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= w_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			fill_q  <= '0;
			rnd_q   <= '0;
			eom_q   <= 1'b0;
			pad_q   <= 1'b0;
			len_q   <= 1'b0;
			zero_q  <= 1'b0;
			oidx_q  <= '0;
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= sha256_pkg::H_INIT[i];
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						eom_q <= end_of_message;
						if (byte_valid) begin
							fill_q  <= fill_q + 6'd1;
							count_q <= count_q + 61'd1;
						end
						if (byte_valid && fill_q == 6'd63) begin
							state_q <= ST_PRE;
						end else if (end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					pad_q   <= 1'b1;
					len_q   <= (fill_q <= 6'd55);
					state_q <= ST_PRE;
				end
				ST_PRE: begin
					rnd_q   <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					for (int i = 0; i < 8; i++) begin
						hash_q[i] <= hash_q[i] + v_q[i];
					end
					if (len_q) begin
						oidx_q  <= '0;
						state_q <= ST_OUT;
					end else if (pad_q) begin
						pad_q   <= 1'b0;
						zero_q  <= 1'b1;
						len_q   <= 1'b1;
						state_q <= ST_PRE;
					end else if (eom_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) begin
								hash_q[i] <= sha256_pkg::H_INIT[i];
							end
							count_q <= '0;
							fill_q  <= '0;
							eom_q   <= 1'b0;
							pad_q   <= 1'b0;
							len_q   <= 1'b0;
							zero_q  <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while digest pending");
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && rnd_q == 6'd63) |=> (state_q == ST_FIN))
		else $error("round loop did not end after 64 rounds");
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last_word) |=> (!out_valid && fill_q == 6'd0 && count_q == 61'd0))
		else $error("engine not cleared after last digest word");
	a_len_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		zero_q |-> (len_q && !pad_q))
		else $error("length block flags inconsistent");
`endif

endmodule

// ----- bench/tb_top.sv -----
// Testbench for the SHA-256 byte-stream digest engine: digest prediction and result checking.
`timescale 1ns / 1ps
module tb_top;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_out_t;

	class digest_scoreboard;
		sha256_pkg::word_t hash_state [8];
		sha256_pkg::word_t block_words [16];
		logic [60:0] msg_bytes;
		int unsigned fill;
		digest_out_t pending [$];
		int unsigned errors;

		function new();
			reload();
			foreach (block_words[i]) block_words[i] = '0;
			errors = 0;
		endfunction

		function void reload();
			foreach (hash_state[i]) hash_state[i] = sha256_pkg::H_INIT[i];
			msg_bytes = '0;
			fill = 0;
		endfunction

		function sha256_pkg::word_t ror32(sha256_pkg::word_t x, int unsigned n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void compress();
			sha256_pkg::word_t sched [16];
			sha256_pkg::word_t v [8];
			sha256_pkg::word_t w, t1, t2, a15, a2;
			sched = block_words;
			v = hash_state;
			for (int r = 0; r < 64; r++) begin
				if (r < 16) begin
					w = sched[r];
				end else begin
					a15 = sched[(r - 15) & 15];
					a2 = sched[(r - 2) & 15];
					w = sched[r & 15] + sched[(r - 7) & 15]
						+ (ror32(a15, 7) ^ ror32(a15, 18) ^ (a15 >> 3))
						+ (ror32(a2, 17) ^ ror32(a2, 19) ^ (a2 >> 10));
					sched[r & 15] = w;
				end
				t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_K[r] + w;
				t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				for (int j = 7; j > 0; j--) v[j] = v[j - 1];
				v[4] = v[4] + t1;
				v[0] = t1 + t2;
			end
			for (int j = 0; j < 8; j++) hash_state[j] = hash_state[j] + v[j];
		endfunction

		function void note_request(logic [7:0] b, logic bv, logic eom);
			int unsigned wi, sh;
			sha256_pkg::word_t keep;
			logic [63:0] bits;
			digest_out_t d;
			if (bv) begin
				wi = fill >> 2;
				sh = 24 - 8 * (fill & 3);
				if ((fill & 3) == 0)
					block_words[wi] = {b, 24'h0};
				else
					block_words[wi] = (block_words[wi]
						& ~(sha256_pkg::word_t'(8'hff) << sh))
						| (sha256_pkg::word_t'(b) << sh);
				fill = (fill + 1) & 63;
				msg_bytes = msg_bytes + 1;
				if (fill == 0) compress();
			end
			if (!eom) return;
			wi = fill >> 2;
			sh = 24 - 8 * (fill & 3);
			keep = (fill & 3) ? (32'hffffffff << (sh + 8)) : 32'h0;
			block_words[wi] = (block_words[wi] & keep) | (sha256_pkg::PAD_BYTE << sh);
			for (int k = wi + 1; k < 16; k++) block_words[k] = '0;
			if (fill > 55) begin
				compress();
				foreach (block_words[i]) block_words[i] = '0;
			end
			bits = {msg_bytes, 3'b000};
			block_words[14] = bits[63:32];
			block_words[15] = bits[31:0];
			compress();
			for (int k = 0; k < 8; k++) begin
				d.word = hash_state[k];
				d.index = 3'(k);
				d.last = (k == 7);
				pending.push_back(d);
			end
			reload();
		endfunction

		function void check_word(digest_out_t got);
			digest_out_t exp_d;
			if (pending.size() == 0) begin
				$display("%0t: unexpected digest word %h idx %0d last %0b",
					$time, got.word, got.index, got.last);
				errors++;
				return;
			end
			exp_d = pending.pop_front();
			if (got.word !== exp_d.word) begin
				$display("%0t: digest_word expected %h actual %h", $time, exp_d.word, got.word);
				errors++;
			end
			if (got.index !== exp_d.index) begin
				$display("%0t: word_index expected %0d actual %0d",
					$time, exp_d.index, got.index);
				errors++;
			end
			if (got.last !== exp_d.last) begin
				$display("%0t: last_word expected %0b actual %0b",
					$time, exp_d.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [7:0]  message_byte = 0;
	logic        byte_valid = 0;
	logic        end_of_message = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	int unsigned send_idle_pct = 35;
	int unsigned recv_idle_pct = 70;
	bit          hold_off = 0;
	longint unsigned cycle_count = 0;
	digest_scoreboard board;

	localparam longint unsigned CYCLE_LIMIT = 400000;

	sha256_message_digest_top dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.message_byte(message_byte), .byte_valid(byte_valid),
		.end_of_message(end_of_message), .out_valid(out_valid), .out_stall(out_stall),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_word(digest_out_t'{digest_word, word_index, last_word});
		if (hold_off)
			out_stall <= 1;
		else
			out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	task automatic send_request(logic [7:0] b, logic bv, logic eom);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		message_byte <= b;
		byte_valid <= bv;
		end_of_message <= eom;
		do @(posedge clk); while (in_stall);
		board.note_request(b, bv, eom);
	endtask

	task automatic send_message(int unsigned len, bit empty_tail, int unsigned fixed);
		for (int unsigned i = 0; i < len; i++) begin
			if ($urandom_range(9) == 0) send_request(8'($urandom), 0, 0);
			send_request(fixed < 256 ? fixed[7:0] : 8'($urandom),
				1, (i == len - 1) && !empty_tail);
		end
		if (empty_tail || len == 0) send_request(8'($urandom), 0, 1);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic int unsigned pick_len();
		case ($urandom_range(5))
			0: return $urandom_range(3);
			1: return $urandom_range(52, 60);
			2: return $urandom_range(60, 70);
			3: return $urandom_range(118, 130);
			default: return $urandom_range(1, 40);
		endcase
	endfunction

	initial begin
		board = new();
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_message(0, 1, 256);
		send_message(1, 0, 0);
		send_message(1, 0, 255);
		send_message(3, 0, 256);
		send_message(55, 0, 256);
		send_message(56, 0, 8'haa);
		send_message(64, 1, 8'h55);
		drain();
		for (int p = 0; p < 3; p++) begin
			int unsigned sent;
			if (p == 1) begin
				send_idle_pct = 70;
				recv_idle_pct = 35;
			end else if (p == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			sent = 0;
			while (sent < 75) begin
				int unsigned len;
				len = pick_len();
				if (p == 0 && sent == 0) begin
					fork
						begin
							hold_off = 1;
							repeat (300) @(posedge clk);
							hold_off = 0;
						end
					join_none
					send_message(20, 0, 256);
					send_message(20, 0, 256);
					len = 0;
					sent = 40;
				end else begin
					send_message(len, $urandom_range(3) == 0, 256);
					sent += len + 1;
				end
			end
			drain();
		end
		if (board.errors == 0 && board.pending.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/sha256_pkg.sv
rtl/sha256_message_digest_top.sv
bench/tb_top.sv
